[rtl/core/mml_pkg.sv]
// ----------------------------------------------------------------------------
// mml_pkg
// Types, constants and helper functions for the music-macro note parser.
// ----------------------------------------------------------------------------
`default_nettype none

package mml_pkg;

  // Parse modes
  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_OCT   = 3'd1,
    MODE_NOTE  = 3'd2,
    MODE_NUM   = 3'd3,
    MODE_LEN   = 3'd4,
    MODE_TEMPO = 3'd5,
    MODE_STYLE = 3'd6,
    MODE_SKIP  = 3'd7
  } mode_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_DIV1 = 3'd1,
    ST_MUL  = 3'd2,
    ST_DIV2 = 3'd3,
    ST_EMIT = 3'd4,
    ST_DOT  = 3'd5
  } seq_e;

  localparam logic [3:0]  STYLE_NORMAL   = 4'd7;
  localparam logic [3:0]  STYLE_LEGATO   = 4'd8;
  localparam logic [3:0]  STYLE_STACCATO = 4'd3;

  localparam logic [7:0]  OCTAVE_RESET = 8'd4;
  localparam logic [7:0]  TEMPO_RESET  = 8'd120;
  localparam logic [15:0] LENGTH_RESET = 16'd400;

  localparam logic [24:0] MS_PER_MIN  = 25'd60000;
  localparam logic [8:0]  LEN_SCALE   = 9'd400;
  localparam logic [4:0]  DIV_STEPS   = 5'd24;   // steps minus one

  // Command and modifier characters
  localparam logic [7:0]  CH_NUL      = 8'h00;
  localparam logic [7:0]  CH_HASH     = 8'h23;
  localparam logic [7:0]  CH_DOLLAR   = 8'h24;
  localparam logic [7:0]  CH_PLUS     = 8'h2B;
  localparam logic [7:0]  CH_MINUS    = 8'h2D;
  localparam logic [7:0]  CH_DOT      = 8'h2E;
  localparam logic [7:0]  CH_ZERO     = 8'h30;
  localparam logic [7:0]  CH_NINE     = 8'h39;
  localparam logic [7:0]  CH_LT       = 8'h3C;
  localparam logic [7:0]  CH_GT       = 8'h3E;
  localparam logic [7:0]  CH_A        = 8'h41;
  localparam logic [7:0]  CH_B        = 8'h42;
  localparam logic [7:0]  CH_C        = 8'h43;
  localparam logic [7:0]  CH_D        = 8'h44;
  localparam logic [7:0]  CH_E        = 8'h45;
  localparam logic [7:0]  CH_F        = 8'h46;
  localparam logic [7:0]  CH_G        = 8'h47;
  localparam logic [7:0]  CH_L        = 8'h4C;
  localparam logic [7:0]  CH_M        = 8'h4D;
  localparam logic [7:0]  CH_N        = 8'h4E;
  localparam logic [7:0]  CH_O        = 8'h4F;
  localparam logic [7:0]  CH_P        = 8'h50;
  localparam logic [7:0]  CH_S        = 8'h53;
  localparam logic [7:0]  CH_T        = 8'h54;
  localparam logic [7:0]  CH_X        = 8'h58;
  localparam logic [7:0]  CH_LC_A     = 8'h61;
  localparam logic [7:0]  CH_LC_Z     = 8'h7A;
  localparam logic [7:0]  CASE_OFFSET = 8'd32;

  // Saturating helpers
  function automatic logic [7:0] sat8(input logic [15:0] v);
    sat8 = (v > 16'd255) ? 8'd255 : v[7:0];
  endfunction

  function automatic logic [15:0] sat16(input logic [24:0] v);
    sat16 = (v > 25'd65535) ? 16'hFFFF : v[15:0];
  endfunction

  // acc*10 + digit, saturated
  function automatic logic [15:0] accum(input logic [15:0] acc, input logic [7:0] c);
    logic [24:0] t;
    t = ({9'd0, acc} << 3) + ({9'd0, acc} << 1) + {21'd0, c[3:0]};
    accum = sat16(t);
  endfunction

  // n*100, saturated
  function automatic logic [15:0] times100(input logic [15:0] n);
    logic [24:0] t;
    t = {9'd0, n} * 25'd100;
    times100 = sat16(t);
  endfunction

  // Semitone offset of a note letter
  function automatic logic [7:0] base_of(input logic [7:0] u);
    case (u)
      CH_A:    base_of = 8'd10;
      CH_B:    base_of = 8'd12;
      CH_C:    base_of = 8'd1;
      CH_D:    base_of = 8'd3;
      CH_E:    base_of = 8'd5;
      CH_F:    base_of = 8'd6;
      CH_G:    base_of = 8'd8;
      default: base_of = 8'd0;
    endcase
  endfunction

endpackage

`default_nettype wire

[rtl/core/mml_note_command_parser_unit.sv]
// ----------------------------------------------------------------------------
// mml_note_command_parser_unit
// Music-macro string parser: one byte per transaction, emits finished notes.
// ----------------------------------------------------------------------------
// Sequence: a note result is registered after its closing byte passes two
//   25-step restoring divisions on one divider, a multiply step and an output
//   step; zero tempo or length skips to the output step. A dot runs one division.
// Flow: in_stall_o holds the next byte while a note or a dot is in progress and
//   while a note waits for the output; bytes are otherwise taken back to back.
// Reset: asynchronous, active low; octave 4, tempo 120, length 400, style 7.
`default_nettype none

module mml_note_command_parser_unit import mml_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  character_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       note_number_o,
  output logic [15:0]      total_ms_o,
  output logic [15:0]      sound_ms_o,
  output logic             bad_timing_o
);

  // Parser state
  mode_e       mode_q, mode_d;
  logic [15:0] acc_q, acc_d;
  logic [7:0]  oct_q, oct_d;
  logic [7:0]  tempo_q, tempo_d;
  logic [15:0] deflen_q, deflen_d;
  logic [15:0] curlen_q, curlen_d;
  logic [7:0]  note_q, note_d;
  logic [3:0]  style_q, style_d;
  logic        run_q, run_d;

  // Snapshot for the note being timed
  logic [7:0]  snote_q;
  logic [3:0]  sstyle_q;
  logic [15:0] slen_q;
  logic        sbad_q;

  // Shared divider
  logic [15:0] rem_q;
  logic [24:0] dvd_q;
  logic [15:0] dvsr_q;
  logic [4:0]  cnt_q;
  logic [16:0] trial;
  logic        ge;
  logic [15:0] rem_step;
  logic [24:0] dvd_step;

  // Output register
  logic        ovalid_q;
  logic [7:0]  onote_q;
  logic [15:0] ototal_q, osound_q;
  logic        obad_q;

  seq_e        st_q, st_d;

  logic        accept, emit, dot, do_idle, out_free;
  logic [7:0]  c, u;
  logic        digit;
  logic [7:0]  snap_note;
  logic [15:0] snap_len;
  logic [7:0]  snap_tempo;
  logic [3:0]  snap_style;
  logic [15:0] acc_base;
  logic [15:0] total;
  logic [19:0] sound_wide;
  logic [15:0] sound;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !ovalid_q || !out_stall_i;
  assign c        = character_i;
  assign u        = (c >= CH_LC_A && c <= CH_LC_Z) ? (c - CASE_OFFSET) : c;
  assign digit    = (c >= CH_ZERO && c <= CH_NINE);

  // Byte decode: mode handling, then the idle command pass
  always_comb begin
    mode_d = mode_q; acc_d = acc_q; oct_d = oct_q; tempo_d = tempo_q;
    deflen_d = deflen_q; curlen_d = curlen_q; note_d = note_q;
    style_d = style_q; run_d = run_q;
    emit = 1'b0; dot = 1'b0; do_idle = 1'b0;
    acc_base = 16'd0;
    case (mode_q)
      MODE_OCT, MODE_LEN, MODE_TEMPO: begin
        if (digit) begin
          acc_d = accum(acc_q, c);
        end else begin
          if (mode_q == MODE_OCT) oct_d = sat8(acc_q);
          else if (mode_q == MODE_LEN) deflen_d = times100(acc_q);
          else tempo_d = sat8(acc_q);
          mode_d  = MODE_IDLE;
          do_idle = 1'b1;
        end
      end
      MODE_NUM: begin
        if (digit) begin
          acc_d = accum(acc_q, c);
        end else begin
          note_d   = sat8(acc_q);
          curlen_d = deflen_q;
          emit     = 1'b1;
          mode_d   = MODE_IDLE;
          do_idle  = 1'b1;
        end
      end
      MODE_NOTE: begin
        if (digit) begin
          acc_base = run_q ? acc_q : 16'd0;
          acc_d    = accum(acc_base, c);
          run_d    = 1'b1;
          curlen_d = times100(acc_d);
        end else begin
          run_d = 1'b0;
          if (c == CH_PLUS || c == CH_HASH) begin
            note_d = note_q + 8'd1;
          end else if (c == CH_MINUS) begin
            note_d = note_q - 8'd1;
          end else if (c == CH_DOT) begin
            dot = 1'b1;
          end else begin
            emit    = 1'b1;
            mode_d  = MODE_IDLE;
            do_idle = 1'b1;
          end
        end
      end
      MODE_STYLE: begin
        mode_d = MODE_IDLE;
        if (c == CH_NUL) begin
          do_idle = 1'b1;
        end else if (u == CH_N) begin
          style_d = STYLE_NORMAL;
        end else if (u == CH_L) begin
          style_d = STYLE_LEGATO;
        end else if (u == CH_S) begin
          style_d = STYLE_STACCATO;
        end
      end
      MODE_SKIP: begin
        if (c == CH_DOLLAR) begin
          mode_d = MODE_IDLE;
        end else if (c == CH_NUL) begin
          mode_d  = MODE_IDLE;
          do_idle = 1'b1;
        end
      end
      default: do_idle = 1'b1;
    endcase

    // values seen by the emitted note
    snap_note  = note_d;
    snap_len   = curlen_d;
    snap_tempo = tempo_d;
    snap_style = style_d;

    if (do_idle) begin
      if (c == CH_NUL) begin
        mode_d  = MODE_IDLE;
        style_d = STYLE_NORMAL;
        run_d   = 1'b0;
      end else begin
        case (u)
          CH_GT: oct_d = oct_d + 8'd1;
          CH_LT: oct_d = oct_d - 8'd1;
          CH_O: begin acc_d = 16'd0; mode_d = MODE_OCT; end
          CH_A, CH_B, CH_C, CH_D, CH_E, CH_F, CH_G, CH_P: begin
            if (u == CH_P) note_d = 8'd0;
            else note_d = 8'((16'(oct_d) * 16'd12) + 16'(base_of(u)));
            curlen_d = deflen_d;
            run_d    = 1'b0;
            mode_d   = MODE_NOTE;
          end
          CH_N: begin acc_d = 16'd0; mode_d = MODE_NUM; end
          CH_L: begin acc_d = 16'd0; mode_d = MODE_LEN; end
          CH_T: begin acc_d = 16'd0; mode_d = MODE_TEMPO; end
          CH_M: mode_d = MODE_STYLE;
          CH_X: mode_d = MODE_SKIP;
          default: ;
        endcase
      end
    end
  end

  // Divider step
  assign trial    = {rem_q, dvd_q[24]};
  assign ge       = trial >= {1'b0, dvsr_q};
  assign rem_step = ge ? 16'(trial - {1'b0, dvsr_q}) : trial[15:0];
  assign dvd_step = {dvd_q[23:0], ge};

  // Timing of the finished note
  assign total      = sbad_q ? 16'd0 : sat16(dvd_q);
  assign sound_wide = (20'(total) * 20'(sstyle_q)) >> 3;
  assign sound      = sat16(25'(sound_wide));

  // Sequencer next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (accept && emit) begin
          st_d = (snap_tempo == 8'd0 || snap_len == 16'd0) ? ST_EMIT : ST_DIV1;
        end else if (accept && dot) begin
          st_d = ST_DOT;
        end
      end
      ST_DIV1: if (cnt_q == 5'd0) st_d = ST_MUL;
      ST_MUL:  st_d = ST_DIV2;
      ST_DIV2: if (cnt_q == 5'd0) st_d = ST_EMIT;
      ST_EMIT: if (out_free) st_d = ST_IDLE;
      ST_DOT:  if (cnt_q == 5'd0) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall_o = (st_q != ST_IDLE);
  end

  // Control and parser registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      mode_q   <= MODE_IDLE;
      acc_q    <= 16'd0;
      oct_q    <= OCTAVE_RESET;
      tempo_q  <= TEMPO_RESET;
      deflen_q <= LENGTH_RESET;
      curlen_q <= LENGTH_RESET;
      note_q   <= 8'd0;
      style_q  <= STYLE_NORMAL;
      run_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (accept) begin
        mode_q   <= mode_d;
        acc_q    <= acc_d;
        oct_q    <= oct_d;
        tempo_q  <= tempo_d;
        deflen_q <= deflen_d;
        curlen_q <= curlen_d;
        note_q   <= note_d;
        style_q  <= style_d;
        run_q    <= run_d;
      end
      if (st_q == ST_DOT && cnt_q == 5'd0) curlen_q <= dvd_step[15:0];
      if (st_q == ST_EMIT && out_free) ovalid_q <= 1'b1;
      else if (!out_stall_i) ovalid_q <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (st_q)
      ST_IDLE: begin
        if (accept && emit) begin
          snote_q  <= snap_note;
          sstyle_q <= snap_style;
          slen_q   <= snap_len;
          sbad_q   <= (snap_tempo == 8'd0 || snap_len == 16'd0);
          rem_q    <= 16'd0;
          dvd_q    <= MS_PER_MIN;
          dvsr_q   <= {8'd0, snap_tempo};
          cnt_q    <= DIV_STEPS;
        end else if (accept && dot) begin
          rem_q  <= 16'd0;
          dvd_q  <= {8'd0, curlen_q, 1'b0};
          dvsr_q <= 16'd3;
          cnt_q  <= DIV_STEPS;
        end
      end
      ST_DIV1, ST_DIV2, ST_DOT: begin
        rem_q <= rem_step;
        dvd_q <= dvd_step;
        cnt_q <= cnt_q - 5'd1;
      end
      ST_MUL: begin
        rem_q  <= 16'd0;
        dvd_q  <= 25'(dvd_q[15:0] * LEN_SCALE);
        dvsr_q <= slen_q;
        cnt_q  <= DIV_STEPS;
      end
      ST_EMIT: begin
        if (out_free) begin
          onote_q  <= snote_q;
          ototal_q <= total;
          osound_q <= sound;
          obad_q   <= sbad_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o   = ovalid_q;
  assign note_number_o = onote_q;
  assign total_ms_o    = ototal_q;
  assign sound_ms_o    = osound_q;
  assign bad_timing_o  = obad_q;

endmodule

`default_nettype wire
